// ===== rtl/core/dra_pkg.sv =====
// Shared constants, codes and the online slot record for the device registry.
`timescale 1ns / 1ps
package dra_pkg;

  localparam int MAX_ONLINE_DEF     = 16;
  localparam int MAX_REGISTERED_DEF = 16;

  localparam logic [31:0] TIMEOUT_RST = 32'd30000;

  localparam logic [2:0] OP_REPORT = 3'd0;
  localparam logic [2:0] OP_PONG   = 3'd1;
  localparam logic [2:0] OP_REG    = 3'd2;
  localparam logic [2:0] OP_UNREG  = 3'd3;
  localparam logic [2:0] OP_SWEEP  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_AUTOREG   = 3'd1;
  localparam logic [2:0] ST_FULL_STOP = 3'd2;
  localparam logic [2:0] ST_NO_SLOT   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  battery;
    logic [7:0]  camera;
    logic [31:0] uptime;
    logic [7:0]  brightness;
    logic        stopped;
    logic [8:0]  rssi;
    logic [7:0]  snr;
    logic [15:0] ping;
    logic [31:0] stamp_ms;
  } slot_rec_t;

endpackage

// ===== rtl/core/dra_reg_cell.sv =====
// One cell of the registration ring: holds a device ID and passes it on when shifted.
`timescale 1ns / 1ps
module dra_reg_cell (
  input  logic        clk,
  input  logic        shift_en,
  input  logic [31:0] d_in,
  output logic [31:0] q
);

  logic [31:0] id_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r <= d_in;
    end
  end

  assign q = id_r;

endmodule

// ===== rtl/core/dra_slot_cell.sv =====
// One cell of the online ring: a valid bit and a slot record, passed on when shifted.
`timescale 1ns / 1ps
module dra_slot_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic                v_in,
  input  dra_pkg::slot_rec_t  rec_in,
  output logic                v_q,
  output dra_pkg::slot_rec_t  rec_q
);
  import dra_pkg::*;

  logic      valid_r;
  slot_rec_t rec_r;

  // Only the valid bit needs reset; a record is read only while valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign v_q   = valid_r;
  assign rec_q = rec_r;

endmodule

// ===== rtl/core/device_registry_with_aging_core.sv =====
// Device registry with aging: registration ring, online ring and the sequencer.
// Each word is captured in idle, then runs the registration pass, the online pass, the write
// pass when a report or pong writes a slot, and the done state, which registers the result.
// One word is processed at a time; the next word is taken only once the block is back in
// idle after the result is registered, so it waits longer while the result is stalled.
// Reset (rst_n low, synchronous) empties both tables, clears the counters and loads the idle
// timeout with 30000. Slot records and IDs are not cleared; valid bits and the count guard them.
`timescale 1ns / 1ps
module device_registry_with_aging_core #(
  parameter int MAX_ONLINE     = dra_pkg::MAX_ONLINE_DEF,
  parameter int MAX_REGISTERED = dra_pkg::MAX_REGISTERED_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_device_id,
  input  logic [7:0]  in_battery,
  input  logic [7:0]  in_camera_id,
  input  logic [31:0] in_uptime,
  input  logic [7:0]  in_brightness,
  input  logic        in_stopped_flag,
  input  logic signed [8:0] in_rssi,
  input  logic signed [7:0] in_snr,
  input  logic [15:0] in_sent_stamp_low,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [15:0] out_round_trip_ms,
  output logic [4:0]  out_online_count,
  output logic [4:0]  out_registered_count,
  output logic [4:0]  out_removed_count,
  output logic        out_changed
);
  import dra_pkg::*;

  // Both tables live in rings of cells. In every pass the ring shifts once per cycle
  // toward cell 0, and cell 0 feeds the last cell, so that in cycle k of a pass the
  // head (cell 0) holds entry k. After a full pass every entry is back in place. An
  // entry is edited by replacing the head value on its way back into the ring.
  localparam int MO   = MAX_ONLINE;
  localparam int MR   = MAX_REGISTERED;
  localparam int MAXN = (MO > MR) ? MO : MR;
  localparam int CW   = $clog2(MAXN + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REG  = 3'd1;
  localparam logic [2:0] S_ONL  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Ring wiring.
  logic [31:0] rq [MR];
  logic [31:0] rd [MR];
  logic        vq [MO];
  logic        vd [MO];
  slot_rec_t   recq [MO];
  slot_rec_t   recd [MO];

  logic        reg_shift;
  logic        onl_shift;
  logic [31:0] reg_head_mod;
  logic        onl_v_mod;
  slot_rec_t   onl_rec_mod;

  for (genvar gi = 0; gi < MR; gi++) begin : g_reg
    if (gi == MR - 1) begin : g_tail
      assign rd[gi] = reg_head_mod;
    end else begin : g_mid
      assign rd[gi] = rq[gi + 1];
    end
    dra_reg_cell u_cell (
      .clk      (clk),
      .shift_en (reg_shift),
      .d_in     (rd[gi]),
      .q        (rq[gi])
    );
  end

  for (genvar gj = 0; gj < MO; gj++) begin : g_onl
    if (gj == MO - 1) begin : g_tail
      assign vd[gj]   = onl_v_mod;
      assign recd[gj] = onl_rec_mod;
    end else begin : g_mid
      assign vd[gj]   = vq[gj + 1];
      assign recd[gj] = recq[gj + 1];
    end
    dra_slot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (onl_shift),
      .v_in     (vd[gj]),
      .rec_in   (recd[gj]),
      .v_q      (vq[gj]),
      .rec_q    (recq[gj])
    );
  end

  // Control and captured word.
  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] timeout_r, timeout_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  bat_r, bat_nxt;
  logic [7:0]  cam_r, cam_nxt;
  logic [31:0] up_r, up_nxt;
  logic [7:0]  bri_r, bri_nxt;
  logic        stp_r, stp_nxt;
  logic [8:0]  rssi_r, rssi_nxt;
  logic [7:0]  snr_r, snr_nxt;
  logic [15:0] sent_r, sent_nxt;
  logic [31:0] now_r, now_nxt;

  logic [CW-1:0] reg_cnt_r, reg_cnt_nxt;
  logic [CW-1:0] onl_cnt_r, onl_cnt_nxt;

  logic          reg_hit_r, reg_hit_nxt;
  logic [CW-1:0] reg_idx_r, reg_idx_nxt;
  logic [31:0]   last_val_r, last_val_nxt;
  logic          rw_en_r, rw_en_nxt;
  logic [CW-1:0] rw_idx_r, rw_idx_nxt;
  logic [31:0]   rw_val_r, rw_val_nxt;

  logic          onl_hit_r, onl_hit_nxt;
  logic [CW-1:0] onl_idx_r, onl_idx_nxt;
  logic          free_ok_r, free_ok_nxt;
  logic [CW-1:0] free_idx_r, free_idx_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic          wr_go_r, wr_go_nxt;
  logic          claim_r, claim_nxt;
  logic [CW-1:0] tgt_r, tgt_nxt;
  logic [2:0]    status_r, status_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [15:0] out_rtt_r, out_rtt_nxt;
  logic [4:0]  out_onl_r, out_onl_nxt;
  logic [4:0]  out_reg_r, out_reg_nxt;
  logic [4:0]  out_rem_r, out_rem_nxt;
  logic        out_chg_r, out_chg_nxt;

  // Per-cycle observations at the ring heads.
  logic          reg_match;
  logic          reg_hit_w;
  logic [CW-1:0] reg_idx_w;
  logic          is_last;
  logic [31:0]   last_w;
  logic          reg_full;
  logic          onl_live;
  logic          onl_match;
  logic          onl_hit_w;
  logic [CW-1:0] onl_idx_w;
  logic          free_w;
  logic [CW-1:0] free_idx_w;
  logic          sweep_hit;
  logic [CW-1:0] removed_w;
  logic [15:0]   rtt;
  slot_rec_t     new_rec;

  assign rtt = now_r[15:0] - sent_r;

  assign reg_match = (cnt_r < reg_cnt_r) && (rq[0] == id_r);
  assign reg_hit_w = reg_hit_r || reg_match;
  assign reg_idx_w = reg_hit_r ? reg_idx_r : cnt_r;
  assign is_last   = (CW'(cnt_r + 1'b1) == reg_cnt_r);
  assign last_w    = is_last ? rq[0] : last_val_r;
  assign reg_full  = (reg_cnt_r == CW'(MR));

  assign onl_live   = (cnt_r < CW'(MO));
  assign onl_match  = onl_live && vq[0] && (recq[0].id == id_r);
  assign onl_hit_w  = onl_hit_r || onl_match;
  assign onl_idx_w  = onl_hit_r ? onl_idx_r : cnt_r;
  assign free_w     = free_ok_r || (onl_live && !vq[0]);
  assign free_idx_w = free_ok_r ? free_idx_r : cnt_r;
  assign sweep_hit  = (op_r == OP_SWEEP) && onl_live && vq[0] &&
                      ((now_r - recq[0].stamp_ms) > timeout_r);
  assign removed_w  = removed_r + CW'(sweep_hit);

  // Record written into the target slot. A claimed slot starts from a cleared record.
  always_comb begin
    if (claim_r) begin
      new_rec    = '0;
      new_rec.id = id_r;
    end else begin
      new_rec = recq[0];
    end
    if (op_r == OP_PONG) begin
      new_rec.ping = rtt;
    end else begin
      new_rec.battery    = bat_r;
      new_rec.camera     = cam_r;
      new_rec.uptime     = up_r;
      new_rec.brightness = bri_r;
      new_rec.stopped    = stp_r;
      new_rec.rssi       = rssi_r;
      new_rec.snr        = snr_r;
    end
    new_rec.stamp_ms = now_r;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    timeout_nxt  = timeout_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    bat_nxt      = bat_r;
    cam_nxt      = cam_r;
    up_nxt       = up_r;
    bri_nxt      = bri_r;
    stp_nxt      = stp_r;
    rssi_nxt     = rssi_r;
    snr_nxt      = snr_r;
    sent_nxt     = sent_r;
    now_nxt      = now_r;
    reg_cnt_nxt  = reg_cnt_r;
    onl_cnt_nxt  = onl_cnt_r;
    reg_hit_nxt  = reg_hit_r;
    reg_idx_nxt  = reg_idx_r;
    last_val_nxt = last_val_r;
    rw_en_nxt    = rw_en_r;
    rw_idx_nxt   = rw_idx_r;
    rw_val_nxt   = rw_val_r;
    onl_hit_nxt  = onl_hit_r;
    onl_idx_nxt  = onl_idx_r;
    free_ok_nxt  = free_ok_r;
    free_idx_nxt = free_idx_r;
    removed_nxt  = removed_r;
    wr_go_nxt    = wr_go_r;
    claim_nxt    = claim_r;
    tgt_nxt      = tgt_r;
    status_nxt   = status_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_rtt_nxt    = out_rtt_r;
    out_onl_nxt    = out_onl_r;
    out_reg_nxt    = out_reg_r;
    out_rem_nxt    = out_rem_r;
    out_chg_nxt    = out_chg_r;

    reg_shift    = 1'b0;
    onl_shift    = 1'b0;
    reg_head_mod = rq[0];
    onl_v_mod    = vq[0];
    onl_rec_mod  = recq[0];

    if (cfg_wr_en) begin
      timeout_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_op;
          id_nxt       = in_device_id;
          bat_nxt      = in_battery;
          cam_nxt      = in_camera_id;
          up_nxt       = in_uptime;
          bri_nxt      = in_brightness;
          stp_nxt      = in_stopped_flag;
          rssi_nxt     = in_rssi;
          snr_nxt      = in_snr;
          sent_nxt     = in_sent_stamp_low;
          now_nxt      = in_now_ms;
          cnt_nxt      = '0;
          reg_hit_nxt  = 1'b0;
          rw_en_nxt    = 1'b0;
          onl_hit_nxt  = 1'b0;
          free_ok_nxt  = 1'b0;
          removed_nxt  = '0;
          wr_go_nxt    = 1'b0;
          claim_nxt    = 1'b0;
          tgt_nxt      = '0;
          status_nxt   = ST_OK;
          state_nxt    = S_REG;
        end
      end

      // Registration pass: look the ID up and catch the last entry.
      S_REG: begin
        reg_shift   = 1'b1;
        reg_hit_nxt = reg_hit_w;
        reg_idx_nxt = reg_idx_w;
        if (is_last) begin
          last_val_nxt = rq[0];
        end
        cnt_nxt = CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(MR - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_ONL;
          case (op_r)
            OP_REPORT: begin
              if (!reg_hit_w) begin
                if (!reg_full) begin
                  rw_en_nxt   = 1'b1;
                  rw_idx_nxt  = reg_cnt_r;
                  rw_val_nxt  = id_r;
                  reg_cnt_nxt = CW'(reg_cnt_r + 1'b1);
                  status_nxt  = ST_AUTOREG;
                end else begin
                  status_nxt = ST_FULL_STOP;
                end
              end
            end
            OP_REG: begin
              if (!reg_hit_w && !reg_full) begin
                rw_en_nxt   = 1'b1;
                rw_idx_nxt  = reg_cnt_r;
                rw_val_nxt  = id_r;
                reg_cnt_nxt = CW'(reg_cnt_r + 1'b1);
              end
            end
            OP_UNREG: begin
              if (!reg_hit_w) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                // The last entry fills the gap unless the gap is the last entry.
                rw_en_nxt   = (CW'(reg_idx_w + 1'b1) < reg_cnt_r);
                rw_idx_nxt  = reg_idx_w;
                rw_val_nxt  = last_w;
                reg_cnt_nxt = CW'(reg_cnt_r - 1'b1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Online pass: lookup, first free slot and the aging sweep, while the
      // registration ring turns once more to take its pending edit.
      S_ONL: begin
        reg_shift = (cnt_r < CW'(MR));
        if (rw_en_r && (cnt_r == rw_idx_r)) begin
          reg_head_mod = rw_val_r;
        end
        onl_shift = onl_live;
        if (sweep_hit) begin
          onl_v_mod = 1'b0;
        end
        onl_hit_nxt  = onl_hit_w;
        onl_idx_nxt  = onl_idx_w;
        free_ok_nxt  = free_w;
        free_idx_nxt = free_idx_w;
        removed_nxt  = removed_w;
        cnt_nxt      = CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(MAXN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
          case (op_r)
            OP_REPORT: begin
              if (status_r != ST_FULL_STOP) begin
                if (onl_hit_w) begin
                  tgt_nxt   = onl_idx_w;
                  wr_go_nxt = 1'b1;
                  state_nxt = S_WR;
                end else if (free_w) begin
                  tgt_nxt     = free_idx_w;
                  claim_nxt   = 1'b1;
                  wr_go_nxt   = 1'b1;
                  onl_cnt_nxt = CW'(onl_cnt_r + 1'b1);
                  state_nxt   = S_WR;
                end else begin
                  status_nxt = ST_NO_SLOT;
                end
              end
            end
            OP_PONG: begin
              if (onl_hit_w) begin
                tgt_nxt   = onl_idx_w;
                wr_go_nxt = 1'b1;
                state_nxt = S_WR;
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            OP_SWEEP: begin
              onl_cnt_nxt = CW'(onl_cnt_r - removed_w);
            end
            default: begin
            end
          endcase
        end
      end

      // Write pass: the target slot takes its new record as it passes the head.
      S_WR: begin
        onl_shift = 1'b1;
        if (cnt_r == tgt_r) begin
          onl_v_mod   = 1'b1;
          onl_rec_mod = new_rec;
        end
        cnt_nxt = CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(MO - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = wr_go_r ? 4'(tgt_r) : 4'd0;
          out_rtt_nxt    = (wr_go_r && (op_r == OP_PONG)) ? rtt : 16'd0;
          out_onl_nxt    = 5'(onl_cnt_r);
          out_reg_nxt    = 5'(reg_cnt_r);
          out_rem_nxt    = 5'(removed_r);
          out_chg_nxt    = wr_go_r || (removed_r != '0);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      timeout_r   <= TIMEOUT_RST;
      reg_cnt_r   <= '0;
      onl_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      timeout_r   <= timeout_nxt;
      reg_cnt_r   <= reg_cnt_nxt;
      onl_cnt_r   <= onl_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    bat_r        <= bat_nxt;
    cam_r        <= cam_nxt;
    up_r         <= up_nxt;
    bri_r        <= bri_nxt;
    stp_r        <= stp_nxt;
    rssi_r       <= rssi_nxt;
    snr_r        <= snr_nxt;
    sent_r       <= sent_nxt;
    now_r        <= now_nxt;
    reg_hit_r    <= reg_hit_nxt;
    reg_idx_r    <= reg_idx_nxt;
    last_val_r   <= last_val_nxt;
    rw_en_r      <= rw_en_nxt;
    rw_idx_r     <= rw_idx_nxt;
    rw_val_r     <= rw_val_nxt;
    onl_hit_r    <= onl_hit_nxt;
    onl_idx_r    <= onl_idx_nxt;
    free_ok_r    <= free_ok_nxt;
    free_idx_r   <= free_idx_nxt;
    removed_r    <= removed_nxt;
    wr_go_r      <= wr_go_nxt;
    claim_r      <= claim_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_rtt_r    <= out_rtt_nxt;
    out_onl_r    <= out_onl_nxt;
    out_reg_r    <= out_reg_nxt;
    out_rem_r    <= out_rem_nxt;
    out_chg_r    <= out_chg_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slot             = out_slot_r;
  assign out_round_trip_ms    = out_rtt_r;
  assign out_online_count     = out_onl_r;
  assign out_registered_count = out_reg_r;
  assign out_removed_count    = out_rem_r;
  assign out_changed          = out_chg_r;

endmodule

// ===== verif/device_registry_with_aging_core_tb.sv =====
// Testbench for the device registry core: directed and random words checked against a predictor.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the registry and the queue of expected result words.
class registry_scoreboard;
  logic [31:0] reg_list [16];
  int unsigned reg_total;
  bit          live [16];
  logic [31:0] live_id [16];
  logic [31:0] seen_ms [16];
  int unsigned live_total;
  logic [31:0] idle_limit;
  logic [38:0] pending_words [$];
  int unsigned errors;

  function void clear();
    reg_total  = 0;
    live_total = 0;
    idle_limit = dra_pkg::TIMEOUT_RST;
    foreach (live[i]) live[i] = 0;
    pending_words.delete();
  endfunction

  function int find_reg(logic [31:0] id);
    for (int i = 0; i < reg_total; i++) if (reg_list[i] == id) return i;
    return -1;
  endfunction

  function int find_live(logic [31:0] id);
    for (int i = 0; i < 16; i++) if (live[i] && live_id[i] == id) return i;
    return -1;
  endfunction

  // Works out the result of one accepted word and queues it.
  function void note_word(logic [2:0] op, logic [31:0] id, logic [15:0] stamp,
                          logic [31:0] now_ms);
    logic [2:0]  st;
    logic [3:0]  slot_no;
    logic [15:0] rtt;
    int          removed, idx, r;
    bit          chg;
    st = dra_pkg::ST_OK; slot_no = 0; rtt = 0; removed = 0; chg = 0;
    case (op)
      dra_pkg::OP_REPORT: begin
        if (find_reg(id) < 0) begin
          if (reg_total < 16) begin
            reg_list[reg_total] = id;
            reg_total++;
            st = dra_pkg::ST_AUTOREG;
          end else st = dra_pkg::ST_FULL_STOP;
        end
        if (st != dra_pkg::ST_FULL_STOP) begin
          idx = find_live(id);
          if (idx < 0) begin
            for (int i = 15; i >= 0; i--) if (!live[i]) idx = i;
            if (idx >= 0) begin
              live[idx] = 1; live_id[idx] = id; live_total++;
            end
          end
          if (idx < 0) st = dra_pkg::ST_NO_SLOT;
          else begin
            seen_ms[idx] = now_ms; slot_no = 4'(idx); chg = 1;
          end
        end
      end
      dra_pkg::OP_PONG: begin
        idx = find_live(id);
        if (idx < 0) st = dra_pkg::ST_NOT_FOUND;
        else begin
          rtt = now_ms[15:0] - stamp;
          seen_ms[idx] = now_ms; slot_no = 4'(idx); chg = 1;
        end
      end
      dra_pkg::OP_REG: begin
        if (find_reg(id) < 0 && reg_total < 16) begin
          reg_list[reg_total] = id; reg_total++;
        end
      end
      dra_pkg::OP_UNREG: begin
        r = find_reg(id);
        if (r < 0) st = dra_pkg::ST_NOT_FOUND;
        else begin
          reg_list[r] = reg_list[reg_total-1];
          reg_total--;
        end
      end
      dra_pkg::OP_SWEEP: begin
        for (int i = 0; i < 16; i++)
          if (live[i] && (now_ms - seen_ms[i]) > idle_limit) begin
            live[i] = 0; removed++;
          end
        live_total -= removed;
        chg = (removed > 0);
      end
      default: ;
    endcase
    pending_words.push_back({st, slot_no, rtt, 5'(live_total), 5'(reg_total),
                             5'(removed), chg});
  endfunction

  function void check_word(logic [2:0] st, logic [3:0] slot_no, logic [15:0] rtt,
                           logic [4:0] onl, logic [4:0] regs, logic [4:0] rem, logic chg);
    logic [38:0] got, want;
    got = {st, slot_no, rtt, onl, regs, rem, chg};
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    want = pending_words.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch expected st=%0d slot=%0d rtt=%0d onl=%0d reg=%0d rem=%0d chg=%0d",
               $time, want[38:36], want[35:32], want[31:16], want[15:11], want[10:6],
               want[5:1], want[0]);
      $display("%0t:          actual   st=%0d slot=%0d rtt=%0d onl=%0d reg=%0d rem=%0d chg=%0d",
               $time, st, slot_no, rtt, onl, regs, rem, chg);
      errors++;
    end
  endfunction
endclass

module device_registry_with_aging_core_tb;
  import dra_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_op = 0;
  logic [31:0] in_device_id = 0;
  logic [7:0]  in_battery = 0, in_camera_id = 0, in_brightness = 0;
  logic [31:0] in_uptime = 0, in_now_ms = 0;
  logic        in_stopped_flag = 0;
  logic signed [8:0] in_rssi = 0;
  logic signed [7:0] in_snr = 0;
  logic [15:0] in_sent_stamp_low = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic [15:0] out_round_trip_ms;
  logic [4:0]  out_online_count, out_registered_count, out_removed_count;
  logic        out_changed;

  device_registry_with_aging_core DUT (.*);

  always #5 clk = ~clk;

  registry_scoreboard board = new();

  // Idle and stall percentages; the current phase sets them.
  int unsigned send_idle_pct = 0, recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  // Running clock for the now_ms field, so that aging sees realistic progress.
  logic [31:0] clock_ms = 0;
  // A small pool of IDs keeps lookups hitting; now and then a fresh one comes in.
  logic [31:0] id_pool [24];

  // The receiver stalls at random; results are checked at the edge they are taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_status, out_slot, out_round_trip_ms, out_online_count,
                       out_registered_count, out_removed_count, out_changed);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: counts cycles where neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("device_registry_with_aging_core_tb: FAIL");
      $finish;
    end
  end

  // Presents one word and holds it until accepted; valid drops only if idling follows.
  task automatic send_word(logic [2:0] op, logic [31:0] id, logic [31:0] now_ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid          <= 1;
    in_op             <= op;
    in_device_id      <= id;
    in_battery        <= $urandom;
    in_camera_id      <= $urandom;
    in_uptime         <= $urandom;
    in_brightness     <= $urandom;
    in_stopped_flag   <= $urandom;
    in_rssi           <= $urandom;
    in_snr            <= $urandom;
    in_sent_stamp_low <= $urandom;
    in_now_ms         <= now_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(op, id, in_sent_stamp_low, now_ms);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_words.size() != 0) @(posedge clk);
    // Room for the block to settle before a register write.
    repeat (60) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    cfg_wr_en   <= 1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.idle_limit = value;
  endtask

  // Random words: mostly reports and pongs on known IDs, registry edits, sweeps, unused op codes.
  task automatic random_words(int count);
    int unsigned pick;
    logic [2:0]  op;
    logic [31:0] id;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_REPORT;
      else if (pick < 60) op = OP_PONG;
      else if (pick < 72) op = OP_REG;
      else if (pick < 84) op = OP_UNREG;
      else if (pick < 97) op = OP_SWEEP;
      else op = 3'($urandom_range(7, 5));
      id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(23)];
      clock_ms += $urandom_range(($urandom_range(3) == 0) ? 60000 : 2000);
      if ($urandom_range(49) == 0) clock_ms = $urandom;
      send_word(op, id, clock_ms);
    end
  endtask

  initial begin
    board.clear();
    board.errors = 0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: every op, both ID extremes, fill and overflow of both tables,
    // a pong on an absent device, unregister of an absent ID, unused op codes,
    // and a sweep on wrapped time.
    send_word(OP_PONG, 32'h0, 32'd100);
    send_word(OP_UNREG, 32'hFFFF_FFFF, 32'd100);
    send_word(OP_REPORT, 32'h0, 32'd0);
    send_word(OP_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_PONG, 32'hFFFF_FFFF, 32'h0001_0005);
    send_word(OP_REG, 32'h0, 32'd5);
    for (int i = 0; i < 14; i++) send_word(OP_REPORT, 32'h100 + i, 32'd10);
    send_word(OP_REPORT, 32'h555, 32'd10);
    send_word(OP_UNREG, 32'h0, 32'd10);
    send_word(OP_REPORT, 32'h666, 32'd10);
    send_word(3'd5, 32'h1, 32'd10);
    send_word(3'd7, 32'h1, 32'd10);
    send_word(OP_SWEEP, 32'h1, 32'h8000_0000);
    drain();

    // Phases with different idle settings and timeouts, extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (phase)
        0: write_timeout(32'd0);
        1: write_timeout(32'hFFFF_FFFF);
        2: write_timeout(32'd30000);
        3: write_timeout(32'd1);
        default: write_timeout($urandom_range(100000));
      endcase
      random_words(165);
      drain();
    end

    if (board.errors == 0 && board.pending_words.size() == 0)
      $display("device_registry_with_aging_core_tb: PASS");
    else
      $display("device_registry_with_aging_core_tb: FAIL");
    $finish;
  end
endmodule
